>>> sv/plct_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Per-label centroid table package
// Shared types and constants for the per-label centroid table core.
// ----------------------------------------------------------------------------
package plct_pkg;

	localparam int CFG_W    = 13;
	localparam int COLOR_W  = 32;
	localparam int SUM_W    = 40;
	localparam int COUNT_W  = 25;
	localparam int CENTER_W = 20;

	localparam logic [CFG_W-1:0] WIDTH_RESET = 13'd4096;

	localparam logic [1:0] ACT_PIXEL = 2'd0;
	localparam logic [1:0] ACT_READ  = 2'd1;
	localparam logic [1:0] ACT_CLEAR = 2'd2;

	localparam logic [7:0] ALPHA_CLEAR = 8'd0;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SRCH,
		ST_MISS,
		ST_ACC,
		ST_FETCH,
		ST_DIV,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic [1:0] action;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [7:0] alpha;
		logic [7:0] entry_index;
	} in_item_t;

	typedef struct packed {
		logic                entry_valid;
		logic [7:0]          label_red;
		logic [7:0]          label_green;
		logic [7:0]          label_blue;
		logic [7:0]          label_alpha;
		logic [CENTER_W-1:0] center_x;
		logic [CENTER_W-1:0] center_y;
		logic [COUNT_W-1:0]  pixel_total;
		logic                overflow;
	} out_item_t;

	typedef struct packed {
		logic [SUM_W-1:0]   col_sum;
		logic [SUM_W-1:0]   row_sum;
		logic [COUNT_W-1:0] count;
	} acc_t;

endpackage

>>> sv/plct_chan_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Per-label centroid table channel
// Valid/ready channel that carries one payload per transaction.
// ----------------------------------------------------------------------------
interface plct_chan_if #(parameter type T = logic);
	logic valid;
	logic ready;
	T     payload;

	modport source(output valid, output payload, input ready);
	modport sink(input valid, input payload, output ready);
endinterface

>>> sv/plct_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Per-label centroid table divider
// Restoring divider that produces one quotient bit per cycle.
// ----------------------------------------------------------------------------
module plct_div #(
	parameter int NUM_W = 48,
	parameter int DEN_W = 25
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic             done,
	output logic [NUM_W-1:0] quot
);

	localparam int STEP_W = $clog2(NUM_W + 1);

	logic             busy_q;
	logic             done_q;
	logic [STEP_W-1:0] cnt_q;
	logic [NUM_W-1:0] quot_q;
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic [DEN_W:0]   trial;
	logic [DEN_W:0]   diff;
	logic             ge;

	assign trial = {rem_q, quot_q[NUM_W-1]};
	assign ge    = trial >= {1'b0, den_q};
	assign diff  = trial - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= STEP_W'(NUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == STEP_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quot_q <= num;
			rem_q  <= '0;
			den_q  <= den;
		end else if (busy_q) begin
			quot_q <= {quot_q[NUM_W-2:0], ge};
			rem_q  <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
		end
	end

	assign done = done_q;
	assign quot = quot_q;

endmodule

>>> sv/per_label_centroid_table_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Per-label centroid table core
// Accumulates column, row and pixel count per opaque RGBA color of a raster
// stream and returns per-entry centroids on request.
// ----------------------------------------------------------------------------
// Channel   Role    Carries
// req       sink    action, pixel RGBA, entry index
// rsp       source  entry color, centroid, pixel count, overflow flag
// cfg       write   image width
//
// A pixel runs a linear search from entry 0 that reads one entry of the color memory
// a cycle, then adds into the matching entry or appends its color as a new entry.
// A read of a filled entry fetches the entry and waits for the bit-serial
// dividers; a read of an empty or out-of-range entry goes straight to the output.
// Clear, transparent pixels and idle codes finish when they are accepted.
// Reset needs no clearing pass; the fill count marks which entries are live.
// A result waits in the output register while the next item is taken; only a
// read that finishes with that register still full stalls.
module per_label_centroid_table_core #(
	parameter int MAX_LABELS = 256,
	parameter int COORD_BITS = 12,
	parameter int FRAC_BITS  = 8
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_wr_en,
	input  logic [plct_pkg::CFG_W-1:0] cfg_wr_data,
	plct_chan_if.sink                req,
	plct_chan_if.source              rsp
);

	localparam int LBITS = (MAX_LABELS > 1) ? $clog2(MAX_LABELS) : 1;
	localparam int FW    = $clog2(MAX_LABELS + 1);
	localparam int CW    = (FW > 8) ? FW : 8;
	localparam int WW    = (COORD_BITS + 1 > plct_pkg::CFG_W) ? COORD_BITS + 1
	                                                           : plct_pkg::CFG_W;
	localparam int NUM_W = plct_pkg::SUM_W + FRAC_BITS;

	localparam logic [plct_pkg::COUNT_W-1:0] COUNT_MAX = '1;
	localparam logic [plct_pkg::SUM_W-1:0]   SUM_MAX   = '1;
	localparam logic [COORD_BITS-1:0]        COORD_MAX = '1;
	localparam logic [NUM_W-1:0] CENTER_MAX = NUM_W'({plct_pkg::CENTER_W{1'b1}});

	plct_pkg::state_t    state_q, state_d;
	logic [plct_pkg::CFG_W-1:0] width_q;
	logic [FW-1:0]         filled_q;
	logic [COORD_BITS-1:0] col_q, row_q, pcol_q, prow_q;
	logic                  full_q;
	logic [LBITS-1:0]      idx_q;
	logic [31:0]           color_q;
	logic                  rd_valid_q;
	logic [31:0]           rd_color_q;
	logic [plct_pkg::COUNT_W-1:0] rd_count_q;
	plct_pkg::out_item_t   out_q, out_d;
	logic                  out_valid_q;

	logic [31:0]        color_mem [MAX_LABELS];
	plct_pkg::acc_t     acc_mem [MAX_LABELS];
	logic [31:0]        color_rd_q;
	plct_pkg::acc_t     acc_rd_q;

	logic               acc_in, out_free, hit, last, room, entry_ok, opaque;
	logic [CW-1:0]      entry_ext;
	logic [LBITS-1:0]   rd_addr, wr_addr;
	logic               color_we, acc_we, div_start;
	plct_pkg::acc_t     wr_acc;
	logic [WW-1:0]      w_eff, col_inc;
	logic [plct_pkg::SUM_W:0] col_add, row_add;
	logic               div_done_x, div_done_y;
	logic [NUM_W-1:0]   quot_x, quot_y;

	assign acc_in    = req.valid && req.ready;
	assign req.ready = (state_q == plct_pkg::ST_IDLE);
	assign out_free  = !out_valid_q || rsp.ready;
	assign hit       = (color_rd_q == color_q);
	assign last      = (FW'(idx_q) + FW'(1)) == filled_q;
	assign room      = filled_q < FW'(MAX_LABELS);
	assign entry_ext = CW'(req.payload.entry_index);
	assign entry_ok  = entry_ext < CW'(filled_q);
	assign opaque    = req.payload.alpha != plct_pkg::ALPHA_CLEAR;

	assign col_add = {1'b0, acc_rd_q.col_sum} + (plct_pkg::SUM_W + 1)'(pcol_q);
	assign row_add = {1'b0, acc_rd_q.row_sum} + (plct_pkg::SUM_W + 1)'(prow_q);

	always_comb begin
		w_eff = WW'(width_q);
		if (w_eff == '0) begin
			w_eff = WW'(1);
		end
		if (w_eff > (WW'(1) << COORD_BITS)) begin
			w_eff = WW'(1) << COORD_BITS;
		end
		col_inc = WW'(col_q) + WW'(1);
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			plct_pkg::ST_IDLE: begin
				if (acc_in) begin
					case (req.payload.action)
						plct_pkg::ACT_PIXEL: begin
							if (opaque) begin
								state_d = (filled_q == '0) ? plct_pkg::ST_MISS
								                           : plct_pkg::ST_SRCH;
							end
						end
						plct_pkg::ACT_READ: begin
							state_d = entry_ok ? plct_pkg::ST_FETCH : plct_pkg::ST_OUT;
						end
						default: state_d = plct_pkg::ST_IDLE;
					endcase
				end
			end
			plct_pkg::ST_SRCH: begin
				if (hit) begin
					state_d = plct_pkg::ST_ACC;
				end else if (last) begin
					state_d = plct_pkg::ST_MISS;
				end
			end
			plct_pkg::ST_MISS:  state_d = plct_pkg::ST_IDLE;
			plct_pkg::ST_ACC:   state_d = plct_pkg::ST_IDLE;
			plct_pkg::ST_FETCH: state_d = plct_pkg::ST_DIV;
			plct_pkg::ST_DIV: begin
				if (div_done_x && div_done_y) begin
					state_d = plct_pkg::ST_OUT;
				end
			end
			plct_pkg::ST_OUT: begin
				if (out_free) begin
					state_d = plct_pkg::ST_IDLE;
				end
			end
			default: state_d = plct_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		rd_addr   = idx_q;
		wr_addr   = idx_q;
		color_we  = 1'b0;
		acc_we    = 1'b0;
		div_start = 1'b0;
		wr_acc.col_sum = col_add[plct_pkg::SUM_W] ? SUM_MAX : col_add[plct_pkg::SUM_W-1:0];
		wr_acc.row_sum = row_add[plct_pkg::SUM_W] ? SUM_MAX : row_add[plct_pkg::SUM_W-1:0];
		wr_acc.count   = acc_rd_q.count + 1'b1;
		unique case (state_q)
			plct_pkg::ST_IDLE: begin
				rd_addr = (req.payload.action == plct_pkg::ACT_READ)
				          ? entry_ext[LBITS-1:0] : '0;
			end
			plct_pkg::ST_SRCH: begin
				rd_addr = hit ? idx_q : idx_q + 1'b1;
			end
			plct_pkg::ST_MISS: begin
				wr_addr        = filled_q[LBITS-1:0];
				color_we       = room;
				acc_we         = room;
				wr_acc.col_sum = plct_pkg::SUM_W'(pcol_q);
				wr_acc.row_sum = plct_pkg::SUM_W'(prow_q);
				wr_acc.count   = plct_pkg::COUNT_W'(1);
			end
			plct_pkg::ST_ACC: begin
				acc_we = acc_rd_q.count < COUNT_MAX;
			end
			plct_pkg::ST_FETCH: begin
				div_start = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		out_d = '0;
		out_d.overflow = full_q;
		if (rd_valid_q) begin
			out_d.entry_valid = 1'b1;
			out_d.label_red   = rd_color_q[7:0];
			out_d.label_green = rd_color_q[15:8];
			out_d.label_blue  = rd_color_q[23:16];
			out_d.label_alpha = rd_color_q[31:24];
			out_d.center_x    = (quot_x > CENTER_MAX) ? '1 : quot_x[plct_pkg::CENTER_W-1:0];
			out_d.center_y    = (quot_y > CENTER_MAX) ? '1 : quot_y[plct_pkg::CENTER_W-1:0];
			out_d.pixel_total = rd_count_q;
		end
	end

	always_ff @(posedge clk) begin
		if (color_we) begin
			color_mem[wr_addr] <= color_q;
		end
		if (acc_we) begin
			acc_mem[wr_addr] <= wr_acc;
		end
		color_rd_q <= color_mem[rd_addr];
		acc_rd_q   <= acc_mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= plct_pkg::ST_IDLE;
			width_q     <= plct_pkg::WIDTH_RESET;
			filled_q    <= '0;
			col_q       <= '0;
			row_q       <= '0;
			full_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_wr_en) begin
				width_q <= cfg_wr_data;
			end
			if (acc_in && req.payload.action == plct_pkg::ACT_PIXEL) begin
				if (col_inc >= w_eff) begin
					col_q <= '0;
					if (row_q != COORD_MAX) begin
						row_q <= row_q + 1'b1;
					end
				end else begin
					col_q <= col_inc[COORD_BITS-1:0];
				end
			end
			if (acc_in && req.payload.action == plct_pkg::ACT_CLEAR) begin
				filled_q <= '0;
				col_q    <= '0;
				row_q    <= '0;
				full_q   <= 1'b0;
			end
			if (state_q == plct_pkg::ST_MISS) begin
				if (room) begin
					filled_q <= filled_q + 1'b1;
				end else begin
					full_q <= 1'b1;
				end
			end
			if (state_q == plct_pkg::ST_OUT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc_in) begin
			color_q    <= {req.payload.alpha, req.payload.blue,
			               req.payload.green, req.payload.red};
			pcol_q     <= col_q;
			prow_q     <= row_q;
			idx_q      <= (req.payload.action == plct_pkg::ACT_READ)
			              ? entry_ext[LBITS-1:0] : '0;
			rd_valid_q <= entry_ok;
		end
		if (state_q == plct_pkg::ST_SRCH && !hit) begin
			idx_q <= idx_q + 1'b1;
		end
		if (state_q == plct_pkg::ST_FETCH) begin
			rd_color_q <= color_rd_q;
			rd_count_q <= acc_rd_q.count;
		end
		if (state_q == plct_pkg::ST_OUT && out_free) begin
			out_q <= out_d;
		end
	end

	plct_div #(
		.NUM_W(NUM_W),
		.DEN_W(plct_pkg::COUNT_W)
	) u_div_x (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.num   (NUM_W'(acc_rd_q.col_sum) << FRAC_BITS),
		.den   (acc_rd_q.count),
		.done  (div_done_x),
		.quot  (quot_x)
	);

	plct_div #(
		.NUM_W(NUM_W),
		.DEN_W(plct_pkg::COUNT_W)
	) u_div_y (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.num   (NUM_W'(acc_rd_q.row_sum) << FRAC_BITS),
		.den   (acc_rd_q.count),
		.done  (div_done_y),
		.quot  (quot_y)
	);

	assign rsp.valid   = out_valid_q;
	assign rsp.payload = out_q;

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Per-label centroid table testbench
// Drives pixel, read, clear and idle transactions into the core under random
// idling on both channels. A scoreboard class keeps its own color table and
// scan position, predicts every read response and compares each accepted
// response field by field.
// ----------------------------------------------------------------------------
module tb;

	localparam int N_SLOTS   = 256;
	localparam int XY_MAX    = 4095;
	localparam int LINE_CAP  = 4096;
	localparam int SETTLE    = 400;
	localparam int STALL_MAX = 6000;
	localparam logic [1:0] ACT_NONE = 2'd3;

	class centroid_board;
		logic [plct_pkg::CFG_W-1:0]    width;
		logic [plct_pkg::COLOR_W-1:0]  color[N_SLOTS];
		logic [plct_pkg::SUM_W-1:0]    xsum[N_SLOTS];
		logic [plct_pkg::SUM_W-1:0]    ysum[N_SLOTS];
		logic [plct_pkg::COUNT_W-1:0]  cnt[N_SLOTS];
		int                            filled;
		int                            col;
		int                            row;
		bit                            spilled;
		plct_pkg::out_item_t           pending[$];
		int                            errors;

		function new();
			width = plct_pkg::WIDTH_RESET;
			errors = 0;
			wipe();
		endfunction

		function void wipe();
			filled = 0;
			col = 0;
			row = 0;
			spilled = 0;
		endfunction

		function logic [plct_pkg::SUM_W-1:0] sat_sum(logic [plct_pkg::SUM_W-1:0] s, int v);
			logic [plct_pkg::SUM_W:0] t;
			t = {1'b0, s} + v;
			return t[plct_pkg::SUM_W] ? {plct_pkg::SUM_W{1'b1}} : t[plct_pkg::SUM_W-1:0];
		endfunction

		function logic [plct_pkg::CENTER_W-1:0] mean(logic [plct_pkg::SUM_W-1:0] s,
		                                             logic [plct_pkg::COUNT_W-1:0] n);
			logic [plct_pkg::SUM_W+8:0] q;
			if (n == 0) return '0;
			q = ({9'd0, s} << 8) / n;
			return (q > {plct_pkg::CENTER_W{1'b1}}) ? {plct_pkg::CENTER_W{1'b1}}
			                                       : q[plct_pkg::CENTER_W-1:0];
		endfunction

		function void note(plct_pkg::in_item_t it);
			logic [plct_pkg::COLOR_W-1:0] c;
			plct_pkg::out_item_t o;
			int hit;
			int w;
			case (it.action)
				plct_pkg::ACT_PIXEL: begin
					if (it.alpha != plct_pkg::ALPHA_CLEAR) begin
						c = {it.alpha, it.blue, it.green, it.red};
						hit = -1;
						for (int i = 0; i < filled; i++)
							if (hit < 0 && color[i] == c) hit = i;
						if (hit < 0 && filled >= N_SLOTS) spilled = 1;
						else begin
							if (hit < 0) begin
								hit = filled;
								color[hit] = c;
								xsum[hit] = '0;
								ysum[hit] = '0;
								cnt[hit] = '0;
								filled++;
							end
							if (cnt[hit] != {plct_pkg::COUNT_W{1'b1}}) begin
								xsum[hit] = sat_sum(xsum[hit], col);
								ysum[hit] = sat_sum(ysum[hit], row);
								cnt[hit] = cnt[hit] + 1'b1;
							end
						end
					end
					w = (width == 0) ? 1 : ((width > LINE_CAP) ? LINE_CAP : width);
					col++;
					if (col >= w) begin
						col = 0;
						if (row < XY_MAX) row++;
					end
				end
				plct_pkg::ACT_CLEAR: wipe();
				plct_pkg::ACT_READ: begin
					o = '0;
					if (it.entry_index < filled) begin
						o.entry_valid = 1;
						{o.label_alpha, o.label_blue, o.label_green, o.label_red} =
							color[it.entry_index];
						o.center_x = mean(xsum[it.entry_index], cnt[it.entry_index]);
						o.center_y = mean(ysum[it.entry_index], cnt[it.entry_index]);
						o.pixel_total = cnt[it.entry_index];
					end
					o.overflow = spilled;
					pending.push_back(o);
				end
				default: ;
			endcase
		endfunction

		function void field(string name, longint unsigned e, longint unsigned a);
			if (e != a) begin
				errors++;
				$display("%0t %s mismatch: expected %0h actual %0h", $time, name, e, a);
			end
		endfunction

		function void check(plct_pkg::out_item_t a);
			plct_pkg::out_item_t e;
			if (pending.size() == 0) begin
				errors++;
				$display("%0t unexpected response: actual %p", $time, a);
				return;
			end
			e = pending.pop_front();
			field("entry_valid", e.entry_valid, a.entry_valid);
			field("label_red", e.label_red, a.label_red);
			field("label_green", e.label_green, a.label_green);
			field("label_blue", e.label_blue, a.label_blue);
			field("label_alpha", e.label_alpha, a.label_alpha);
			field("center_x", e.center_x, a.center_x);
			field("center_y", e.center_y, a.center_y);
			field("pixel_total", e.pixel_total, a.pixel_total);
			field("overflow", e.overflow, a.overflow);
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic cfg_wr_en = 0;
	logic [plct_pkg::CFG_W-1:0] cfg_wr_data = '0;
	bit calm = 0;
	int ready_hold = 0;
	int idle_cycles = 0;
	logic [plct_pkg::COLOR_W-1:0] palette[8];
	centroid_board board = new();

	plct_chan_if #(.T(plct_pkg::in_item_t)) req_if();
	plct_chan_if #(.T(plct_pkg::out_item_t)) rsp_if();

	per_label_centroid_table_core i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.req(req_if),
		.rsp(rsp_if)
	);

	always #6 clk = ~clk;

	initial begin
		req_if.valid = 0;
		req_if.payload = '0;
		rsp_if.ready = 0;
	end

	always @(negedge clk) begin
		if (ready_hold > 0) begin
			ready_hold--;
			rsp_if.ready = 0;
		end else if (!calm && $urandom_range(0, 7) == 0) begin
			ready_hold = $urandom_range(0, 15);
			rsp_if.ready = 0;
		end else begin
			rsp_if.ready = 1;
		end
	end

	always @(posedge clk) begin
		if (rsp_if.valid && rsp_if.ready) board.check(rsp_if.payload);
		if ((rsp_if.valid && rsp_if.ready) || (req_if.valid && req_if.ready))
			idle_cycles = 0;
		else if (arst_n) idle_cycles++;
		if (idle_cycles > STALL_MAX) begin
			$display("tb: errors");
			$finish;
		end
	end

	task automatic send(plct_pkg::in_item_t it);
		if (!calm && $urandom_range(0, 7) == 0) begin
			req_if.valid = 0;
			repeat ($urandom_range(1, 16)) @(negedge clk);
		end
		req_if.valid = 1;
		req_if.payload = it;
		do @(posedge clk); while (!req_if.ready);
		board.note(it);
		@(negedge clk);
	endtask

	task automatic drain();
		req_if.valid = 0;
		while (board.pending.size() != 0) @(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic set_width(logic [plct_pkg::CFG_W-1:0] w);
		drain();
		cfg_wr_en = 1;
		cfg_wr_data = w;
		@(negedge clk);
		cfg_wr_en = 0;
		board.width = w;
	endtask

	function automatic plct_pkg::in_item_t pixel(logic [plct_pkg::COLOR_W-1:0] c);
		plct_pkg::in_item_t it;
		it = '0;
		it.action = plct_pkg::ACT_PIXEL;
		{it.alpha, it.blue, it.green, it.red} = c;
		return it;
	endfunction

	function automatic plct_pkg::in_item_t read_of(int idx);
		plct_pkg::in_item_t it;
		it = plct_pkg::in_item_t'($urandom());
		it.action = plct_pkg::ACT_READ;
		it.entry_index = 8'(idx);
		return it;
	endfunction

	function automatic plct_pkg::in_item_t ctl(logic [1:0] a);
		plct_pkg::in_item_t it;
		it = plct_pkg::in_item_t'($urandom());
		it.action = a;
		return it;
	endfunction

	function automatic plct_pkg::in_item_t random_item();
		plct_pkg::in_item_t it;
		int r;
		r = $urandom_range(0, 99);
		if (r < 68) begin
			if ($urandom_range(0, 9) == 0) it = pixel($urandom());
			else it = pixel(palette[$urandom_range(0, 7)]);
			if ($urandom_range(0, 7) == 0) it.alpha = plct_pkg::ALPHA_CLEAR;
			it.entry_index = 8'($urandom());
		end else if (r < 94) begin
			if ($urandom_range(0, 5) == 0) it = read_of($urandom_range(0, 255));
			else it = read_of($urandom_range(0, board.filled + 1));
		end else if (r < 97) begin
			it = ctl(plct_pkg::ACT_CLEAR);
		end else begin
			it = ctl(ACT_NONE);
		end
		return it;
	endfunction

	initial begin
		logic [plct_pkg::CFG_W-1:0] widths[8];
		plct_pkg::in_item_t it;
		widths = '{13'd1, 13'd4096, 13'd2, 13'd8191, 13'd3, 13'd17, 13'd640, 13'd4095};
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		@(negedge clk);

		send(read_of(0));
		send(pixel(32'h0000_0000));
		send(pixel(32'hFFFF_FFFF));
		send(pixel(32'h01FF_00FF));
		send(pixel(32'h8000_FF00));
		send(pixel(32'hFFFF_FFFF));
		send(pixel(32'h00FF_FFFF));
		send(ctl(ACT_NONE));
		send(pixel(32'h01FF_00FF));
		send(read_of(0));
		send(read_of(1));
		send(read_of(2));
		send(read_of(3));
		send(read_of(255));
		send(ctl(plct_pkg::ACT_CLEAR));
		send(read_of(0));
		set_width(13'd3);
		for (int i = 0; i < 7; i++) send(pixel(32'hA5A5_5A5A ^ i[1:0]));
		send(read_of(0));
		send(read_of(3));
		set_width(13'd1);
		send(pixel(32'h7F00_0001));
		send(read_of(0));

		for (int p = 0; p < 10; p++) begin
			for (int k = 0; k < 8; k++) palette[k] = $urandom() | 32'h0100_0000;
			if (p == 9) calm = 1;
			set_width((p < 8) ? widths[p] : plct_pkg::CFG_W'($urandom_range(1, 4096)));
			if (p == 2) begin
				send(ctl(plct_pkg::ACT_CLEAR));
				for (int i = 0; i < 260; i++) send(pixel({8'hFF, 16'h0, 8'(i)} ^ {i[8], 31'h0}));
				send(pixel({8'hFF, 24'h0}));
				send(read_of(255));
				drain();
			end
			if (p == 4) begin
				send(ctl(plct_pkg::ACT_CLEAR));
				set_width(13'd1);
				for (int i = 0; i < 200; i++) send(pixel(32'h0));
				send(pixel(32'hFFFF_FFFF));
				send(pixel(32'hFFFF_FFFF));
				send(read_of(0));
				drain();
			end
			if (p == 6) begin
				for (int i = 0; i < 20; i++) send(random_item());
				drain();
			end
			if ($urandom_range(0, 1) == 0) send(ctl(plct_pkg::ACT_CLEAR));
			for (int i = 0; i < 120; i++) begin
				it = random_item();
				send(it);
			end
		end

		req_if.valid = 0;
		while (board.pending.size() != 0) @(negedge clk);
		repeat (SETTLE) @(negedge clk);
		if (board.errors == 0) $display("tb: clean");
		else $display("tb: errors");
		$finish;
	end
endmodule

>>> filelist.f
sv/plct_pkg.sv
sv/plct_chan_if.sv
sv/plct_div.sv
sv/per_label_centroid_table_core.sv
tb/tb.sv
